### rtl/core/b64d_pkg.sv
// shared types and constants for the base64 stream decoder
// no dependencies; imported by every module of the block but the checker
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // one queued job: a complete group to emit, or the error marker
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    logic        last;
    logic        err;
  } b64d_job_t;

  // bit 6 set when the character is outside the alphabet
  function automatic logic [6:0] b64d_sextet(input logic [7:0] ch);
    logic [6:0] res;
    res = 7'h40;
    if (ch inside {[8'h41:8'h5A]}) begin
      res = {1'b0, 6'(ch - 8'h41)};
    end else if (ch inside {[8'h61:8'h7A]}) begin
      res = {1'b0, 6'(ch - 8'd71)};
    end else if (ch inside {[8'h30:8'h39]}) begin
      res = {1'b0, 6'(ch + 8'd4)};
    end else if (ch == 8'h2B) begin
      res = {1'b0, 6'd62};
    end else if (ch == 8'h2F) begin
      res = {1'b0, 6'd63};
    end
    return res;
  endfunction

endpackage

### rtl/core/b64d_front.sv
// front end: takes characters, checks padding and length, builds groups
// depends on b64d_pkg; pushes jobs into the job queue
module b64d_front import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] char_code_i,
  input  logic       is_final_char_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output b64d_job_t  job_o
);

  logic [1:0]  pos_q, pos_d;
  logic [17:0] acc_q, acc_d;
  logic        pad3_q, pad3_d;
  logic        err_q, err_d;

  logic [6:0] sx;
  logic [5:0] val;
  logic       is_pad;
  logic       err_n;
  logic       pad3_n;
  logic       group_done;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    sx     = b64d_sextet(char_code_i);
    is_pad = (char_code_i == PAD_CHAR);
    val    = sx[5:0];
    err_n  = err_q;
    pad3_n = pad3_q;
    if (!err_q) begin
      // padding is only a zero sextet in the third or fourth place
      if (is_pad && pos_q[1]) begin
        val = '0;
      end else if (sx[6]) begin
        err_n = 1'b1;
      end
      if (!err_n) begin
        if (pos_q == 2'd2 && is_pad) pad3_n = 1'b1;
        if (pos_q == 2'd3) begin
          if (is_pad && !is_final_char_i) err_n = 1'b1;
          if (!is_pad && pad3_q) err_n = 1'b1;
        end
        if (is_final_char_i && pos_q != 2'd3) err_n = 1'b1;
      end
    end
    group_done = !err_n && (pos_q == 2'd3);

    job_o.word  = {acc_q, val};
    job_o.last  = is_final_char_i;
    job_o.err   = 1'b0;
    job_o.count = 2'd3;
    if (is_final_char_i) begin
      if (pad3_q) begin
        job_o.count = 2'd1;
      end else if (is_pad) begin
        job_o.count = 2'd2;
      end
    end
    if (is_final_char_i && err_n) begin
      job_o.word  = '0;
      job_o.count = 2'd1;
      job_o.err   = 1'b1;
    end
    push_o = accept && (group_done || (is_final_char_i && err_n));

    pos_d  = pos_q;
    acc_d  = acc_q;
    pad3_d = pad3_q;
    err_d  = err_q;
    if (accept) begin
      if (is_final_char_i) begin
        pos_d  = '0;
        acc_d  = '0;
        pad3_d = 1'b0;
        err_d  = 1'b0;
      end else if (err_n) begin
        err_d = 1'b1;
      end else if (pos_q != 2'd3) begin
        acc_d  = {acc_q[11:0], val};
        pos_d  = pos_q + 2'd1;
        pad3_d = pad3_n;
      end else begin
        pos_d  = '0;
        acc_d  = '0;
        pad3_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      acc_q  <= '0;
      pad3_q <= 1'b0;
      err_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      pad3_q <= pad3_d;
      err_q  <= err_d;
    end
  end

endmodule

### rtl/core/b64d_fifo.sv
// short job queue between front and back end
// depends on b64d_pkg for the job type
module b64d_fifo import b64d_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  b64d_job_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output b64d_job_t head_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  b64d_job_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/b64d_back.sv
// back end: splits each queued group into bytes, one per cycle while out_stall_i is low
// depends on b64d_pkg; drives the registered output channel
module b64d_back import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  b64d_job_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_output_o,
  output logic       decode_error_o
);

  logic [1:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] data_q, data_d;
  logic       bv_q, bv_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic       load;
  logic       done;
  logic [7:0] sel_byte;

  assign load = q_valid_i && (!vld_q || !out_stall_i);
  assign done = head_i.err || (idx_q == 2'(head_i.count - 2'd1));
  assign pop_o = load && done;

  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.word[23:16];
      2'd1:    sel_byte = head_i.word[15:8];
      default: sel_byte = head_i.word[7:0];
    endcase

    idx_d  = idx_q;
    vld_d  = vld_q;
    data_d = data_q;
    bv_d   = bv_q;
    last_d = last_q;
    err_d  = err_q;
    if (load) begin
      vld_d  = 1'b1;
      data_d = head_i.err ? 8'h00 : sel_byte;
      bv_d   = !head_i.err;
      last_d = head_i.last && done;
      err_d  = head_i.err;
      idx_d  = done ? 2'd0 : idx_q + 2'd1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    bv_q   <= bv_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_valid_o     = vld_q;
  assign data_byte_o     = data_q;
  assign byte_valid_o    = bv_q;
  assign end_of_output_o = last_q;
  assign decode_error_o  = err_q;

endmodule

### rtl/core/base64_stream_decoder_top.sv
// throughput: one character per cycle in while in_stall_o is low; one byte per cycle
// out while out_stall_i is low, at most three per group
// the byte splitter in the back end sets the output rate; the job queue absorbs bursts
// reset (rst_ni, asynchronous, active low) clears group state, queue pointers and out valid
// top level of the base64 stream decoder; depends on b64d_pkg, b64d_front,
// b64d_fifo and b64d_back
module base64_stream_decoder_top import b64d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       is_final_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_output_o,
  output logic       decode_error_o
);

  b64d_job_t push_job;
  b64d_job_t head_job;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;

  b64d_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .char_code_i     (char_code_i),
    .is_final_char_i (is_final_char_i),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .job_o           (push_job)
  );

  b64d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_job)
  );

  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .head_i          (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_byte_o     (data_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_output_o (end_of_output_o),
    .decode_error_o  (decode_error_o)
  );

endmodule

### rtl/core/b64d_checker.sv
// port-level checks on the base64 stream decoder output channel
// depends on nothing; bound to base64_stream_decoder_top below
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_output_o,
  input logic       decode_error_o
);

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // the error item always closes the stream
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> end_of_output_o)
    else $error("error item without end flag");

  // the error item carries no byte
  a_err_nobyte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> !byte_valid_o && data_byte_o == 8'h00)
    else $error("error item carries data");

  // every item is either a byte or the error marker
  a_item_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_valid_o || decode_error_o)
    else $error("item is neither byte nor error");

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .data_byte_o     (data_byte_o),
  .byte_valid_o    (byte_valid_o),
  .end_of_output_o (end_of_output_o),
  .decode_error_o  (decode_error_o)
);

### verif/tb_base64_stream_decoder_top.sv
// testbench for base64_stream_decoder_top: directed table, then random streams
// checked byte by byte against a predictor of the decoder's behaviour
// depends on b64d_pkg and the rtl of the decoder
module tb_base64_stream_decoder_top;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIR    = 26;
  localparam int RAND_ITEMS = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       eos;
    logic       err;
  } dec_out_t;

  // how a directed row's outcome is found: from the predictor or written out by hand
  typedef enum logic [1:0] {
    EXP_MODEL,
    EXP_ZERO_GROUP,
    EXP_ONES_LAST,
    EXP_ERROR
  } exp_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    exp_kind_e  kind;
  } dir_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SOME,
    STALL_ALT,
    STALL_HEAVY
  } stall_mode_e;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // all-zero group, then all-ones group as the final one
    '{"A", 1'b0, EXP_MODEL}, '{"A", 1'b0, EXP_MODEL}, '{"A", 1'b0, EXP_MODEL},
    '{"A", 1'b0, EXP_ZERO_GROUP},
    '{"/", 1'b0, EXP_MODEL}, '{"/", 1'b0, EXP_MODEL}, '{"/", 1'b0, EXP_MODEL},
    '{"/", 1'b1, EXP_ONES_LAST},
    // double padding, nonzero bits hidden below it
    '{"T", 1'b0, EXP_MODEL}, '{"R", 1'b0, EXP_MODEL},
    '{PAD_CHAR, 1'b0, EXP_MODEL}, '{PAD_CHAR, 1'b1, EXP_MODEL},
    // padding in third place followed by a real character
    '{"A", 1'b0, EXP_MODEL}, '{"B", 1'b0, EXP_MODEL},
    '{PAD_CHAR, 1'b0, EXP_MODEL}, '{"C", 1'b1, EXP_ERROR},
    // padding in first place
    '{PAD_CHAR, 1'b1, EXP_ERROR},
    // characters outside the alphabet at both extremes
    '{8'h00, 1'b0, EXP_MODEL}, '{8'hFF, 1'b1, EXP_ERROR},
    // padding closing a group that is not final, characters after the error
    '{"A", 1'b0, EXP_MODEL}, '{"B", 1'b0, EXP_MODEL}, '{"C", 1'b0, EXP_MODEL},
    '{PAD_CHAR, 1'b0, EXP_MODEL}, '{"A", 1'b1, EXP_ERROR},
    // stream cut short
    '{"A", 1'b0, EXP_MODEL}, '{"B", 1'b1, EXP_ERROR}
  };

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_code_i     = 8'h00;
  logic       is_final_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       end_of_output_o;
  logic       decode_error_o;

  // predictor state
  logic [1:0]  grp_pos    = '0;
  logic [17:0] sextet_acc = '0;
  logic        third_pad  = 1'b0;
  logic        err_hold   = 1'b0;

  dec_out_t   model_out [$];
  dec_out_t   bytes_due [$];
  logic [7:0] stream_txt [$];

  int mismatch_cnt = 0;
  int chars_sent   = 0;
  int streams_sent = 0;
  int bytes_seen   = 0;
  int errors_seen  = 0;
  int burst_left   = 0;
  int stall_left   = 0;
  stall_mode_e stall_mode = STALL_NONE;

  base64_stream_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .is_final_char_i(is_final_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .end_of_output_o(end_of_output_o),
    .decode_error_o (decode_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic bit alpha_value(input logic [7:0] ch, output logic [5:0] sx);
    bit ok;
    ok = 1'b1;
    sx = '0;
    if (ch >= "A" && ch <= "Z") begin
      sx = 6'(ch - "A");
    end else if (ch >= "a" && ch <= "z") begin
      sx = 6'(ch - "a" + 8'd26);
    end else if (ch >= "0" && ch <= "9") begin
      sx = 6'(ch - "0" + 8'd52);
    end else if (ch == "+") begin
      sx = 6'd62;
    end else if (ch == "/") begin
      sx = 6'd63;
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [5:0] sx);
    logic [7:0] ch;
    if (sx < 6'd26) begin
      ch = 8'("A" + sx);
    end else if (sx < 6'd52) begin
      ch = 8'("a" + sx - 8'd26);
    end else if (sx < 6'd62) begin
      ch = 8'("0" + sx - 8'd52);
    end else if (sx == 6'd62) begin
      ch = "+";
    end else begin
      ch = "/";
    end
    return ch;
  endfunction

  // advances the predictor by one character, leaves its outputs in model_out
  function automatic void decode_char_step(input logic [7:0] ch, input logic fin);
    logic [5:0]  sx;
    logic [23:0] word;
    logic        pad;
    int          cnt;
    sx = '0;
    pad = (ch == PAD_CHAR);
    model_out.delete();
    if (!err_hold) begin
      if (!(pad && grp_pos >= 2'd2)) begin
        if (!alpha_value(ch, sx)) err_hold = 1'b1;
      end
      if (!err_hold) begin
        if (grp_pos == 2'd2 && pad) third_pad = 1'b1;
        if (grp_pos == 2'd3) begin
          if (pad && !fin) err_hold = 1'b1;
          if (!pad && third_pad) err_hold = 1'b1;
        end
        if (fin && grp_pos != 2'd3) err_hold = 1'b1;
      end
      if (!err_hold) begin
        if (grp_pos != 2'd3) begin
          sextet_acc = {sextet_acc[11:0], sx};
          grp_pos    = grp_pos + 2'd1;
        end else begin
          word = {sextet_acc, sx};
          cnt  = 3;
          if (fin && third_pad) cnt = 1;
          else if (fin && pad) cnt = 2;
          for (int i = 0; i < cnt; i++) begin
            model_out.push_back(dec_out_t'{word[23 - 8*i -: 8], 1'b1,
                                           fin && (i == cnt - 1), 1'b0});
          end
          grp_pos    = '0;
          sextet_acc = '0;
          third_pad  = 1'b0;
        end
      end
    end
    if (fin) begin
      if (err_hold) begin
        model_out.delete();
        model_out.push_back(dec_out_t'{8'h00, 1'b0, 1'b1, 1'b1});
      end
      grp_pos    = '0;
      sextet_acc = '0;
      third_pad  = 1'b0;
      err_hold   = 1'b0;
    end
  endfunction

  // sender: bursts of items with random gaps in between
  task automatic send_char(input logic [7:0] ch, input logic fin, input exp_kind_e kind);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                 $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    char_code_i     <= ch;
    is_final_char_i <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    decode_char_step(ch, fin);
    case (kind)
      EXP_ZERO_GROUP: begin
        repeat (3) bytes_due.push_back(dec_out_t'{8'h00, 1'b1, 1'b0, 1'b0});
      end
      EXP_ONES_LAST: begin
        for (int i = 0; i < 3; i++)
          bytes_due.push_back(dec_out_t'{8'hFF, 1'b1, i == 2, 1'b0});
      end
      EXP_ERROR: begin
        bytes_due.push_back(dec_out_t'{8'h00, 1'b0, 1'b1, 1'b1});
      end
      default: begin
        foreach (model_out[i]) bytes_due.push_back(model_out[i]);
      end
    endcase
  endtask

  // hold the sender off until every decoded byte has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (bytes_due.size() != 0) @(posedge clk_i);
  endtask

  // one random stream: mostly well formed, some with a single fault, some noise
  function automatic void make_stream();
    int kind;
    int groups;
    int pads;
    int pos;
    kind = $urandom_range(0, 9);
    stream_txt.delete();
    groups = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    for (int i = 0; i < 4 * groups; i++) stream_txt.push_back(alpha_char(6'($urandom)));
    pads = $urandom_range(0, 2);
    for (int p = 0; p < pads; p++) stream_txt[stream_txt.size() - 1 - p] = PAD_CHAR;
    if (kind == 7) begin
      pos = $urandom_range(0, stream_txt.size() - 1);
      stream_txt[pos] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
    end else if (kind == 8) begin
      if ($urandom_range(0, 1) || stream_txt.size() == 1)
        stream_txt.push_back(alpha_char(6'($urandom)));
      else
        void'(stream_txt.pop_back());
    end else if (kind == 9) begin
      stream_txt.delete();
      repeat ($urandom_range(1, 9)) stream_txt.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // receiver stall pattern, switching to a random mode whenever stall_left runs out
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_SOME:  out_stall_i <= ($urandom_range(0, 2) == 0);
      STALL_ALT:   out_stall_i <= ~out_stall_i;
      default:     out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    dec_out_t got;
    dec_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{data_byte_o, byte_valid_o, end_of_output_o, decode_error_o};
      if (got.vld === 1'b1) bytes_seen++;
      if (got.err === 1'b1) errors_seen++;
      if (bytes_due.size() == 0) begin
        $error("unexpected item: data_byte %02h byte_valid %b end_of_output %b decode_error %b",
               got.data, got.vld, got.eos, got.err);
        mismatch_cnt++;
      end else begin
        want = bytes_due.pop_front();
        if (got.data !== want.data) begin
          $error("data_byte: expected %02h, actual %02h", want.data, got.data);
          mismatch_cnt++;
        end
        if (got.vld !== want.vld) begin
          $error("byte_valid: expected %b, actual %b", want.vld, got.vld);
          mismatch_cnt++;
        end
        if (got.eos !== want.eos) begin
          $error("end_of_output: expected %b, actual %b", want.eos, got.eos);
          mismatch_cnt++;
        end
        if (got.err !== want.err) begin
          $error("decode_error: expected %b, actual %b", want.err, got.err);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      send_char(DIR_ROWS[i].ch, DIR_ROWS[i].fin, DIR_ROWS[i].kind);
      if (DIR_ROWS[i].fin) streams_sent++;
    end
    drain_results();

    while (chars_sent < NUM_DIR + RAND_ITEMS) begin
      make_stream();
      foreach (stream_txt[i])
        send_char(stream_txt[i], i == stream_txt.size() - 1, EXP_MODEL);
      streams_sent++;
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d characters over %0d streams, %0d of them from the directed table",
             chars_sent, streams_sent, NUM_DIR);
    $display("checked %0d decoded bytes and %0d error markers", bytes_seen, errors_seen);
    if (mismatch_cnt == 0 && bytes_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/b64d_pkg.sv
rtl/core/b64d_front.sv
rtl/core/b64d_fifo.sv
rtl/core/b64d_back.sv
rtl/core/base64_stream_decoder_top.sv
rtl/core/b64d_checker.sv
verif/tb_base64_stream_decoder_top.sv
